>>> hw/rtl/ahfb_pkg.sv
// Shared types, codes and helpers for the ASCII hex frame builder.
package ahfb_pkg;

	localparam int unsigned MaxDigits = 8;

	localparam logic [2:0] ACT_HEX_SUM   = 3'd0;
	localparam logic [2:0] ACT_HEX_NOSUM = 3'd1;
	localparam logic [2:0] ACT_RAW       = 3'd2;
	localparam logic [2:0] ACT_CLOSE_CKS = 3'd3;
	localparam logic [2:0] ACT_CLOSE_NO  = 3'd4;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] value;
		logic [3:0]  digits;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
		logic       frame_end;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEX,
		ST_RAW,
		ST_CR,
		ST_LF
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_hex;
		logic load_raw;
		logic load_cks;
		logic sum_en;
		logic step_hex;
		logic hex_last;
		logic emit_raw;
		logic emit_cr;
		logic emit_lf;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic last_digit;
	} status_t;

	// nibble to upper-case ASCII hex
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		c = {4'h0, nib} + 8'h30;
		if (c > 8'h39) begin
			c = c + 8'h07;
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/ahfb_ctrl.sv
// Sequencer for the frame builder: at most one output beat per cycle, stalled while the output register is full.
module ahfb_ctrl import ahfb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [2:0] action,
	output logic     in_ready,
	input  status_t  status,
	output cmd_t     cmd
);

	state_t state_q, state_nxt;
	logic   close_q, close_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			close_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			close_q <= close_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		close_nxt = close_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					close_nxt = 1'b0;
					unique case (action)
						ACT_HEX_SUM, ACT_HEX_NOSUM: state_nxt = ST_HEX;
						ACT_RAW:                    state_nxt = ST_RAW;
						ACT_CLOSE_CKS: begin
							state_nxt = ST_HEX;
							close_nxt = 1'b1;
						end
						ACT_CLOSE_NO:               state_nxt = ST_CR;
						default:                    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_HEX: begin
				if (status.out_free && status.last_digit) begin
					state_nxt = close_q ? ST_CR : ST_IDLE;
				end
			end
			ST_RAW: if (status.out_free) state_nxt = ST_IDLE;
			ST_CR:  if (status.out_free) state_nxt = ST_LF;
			ST_LF:  if (status.out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_hex = in_valid && (action == ACT_HEX_SUM || action == ACT_HEX_NOSUM);
				cmd.sum_en   = (action == ACT_HEX_SUM);
				cmd.load_raw = in_valid && (action == ACT_RAW);
				cmd.load_cks = in_valid && (action == ACT_CLOSE_CKS);
			end
			ST_HEX: begin
				cmd.step_hex = status.out_free;
				cmd.hex_last = status.last_digit && !close_q;
			end
			ST_RAW:  cmd.emit_raw = status.out_free;
			ST_CR:   cmd.emit_cr  = status.out_free;
			ST_LF:   cmd.emit_lf  = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

>>> hw/rtl/ahfb_dp.sv
// Datapath: digit shifter, running sum and output register.
module ahfb_dp import ahfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output status_t   status,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [31:0] val_q;
	logic [3:0]  cnt_q;
	logic [7:0]  sum_q;
	logic        sum_en_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [3:0]  ndig;
	logic [3:0]  pad;
	logic [4:0]  sh_amt;
	logic [7:0]  hex_byte;
	logic        emit;

	// clamp digit count to 1..8
	always_comb begin
		ndig = in_data.digits;
		if (ndig == 4'd0) begin
			ndig = 4'd1;
		end else if (ndig > 4'(MaxDigits)) begin
			ndig = 4'(MaxDigits);
		end
		pad    = 4'(MaxDigits) - ndig;
		sh_amt = {pad[2:0], 2'b00};
	end

	assign hex_byte = hex_char(val_q[31:28]);
	assign emit     = cmd.step_hex || cmd.emit_raw || cmd.emit_cr || cmd.emit_lf;

	assign status.out_free   = !out_valid_q || out_ready;
	assign status.last_digit = (cnt_q == 4'd1);

	always_ff @(posedge clk) begin
		if (cmd.load_hex) begin
			val_q    <= in_data.value << sh_amt;  // current digit sits in the top nibble
			cnt_q    <= ndig;
			sum_en_q <= cmd.sum_en;
		end else if (cmd.load_raw) begin
			val_q <= in_data.value;
		end else if (cmd.load_cks) begin
			val_q    <= {sum_q, 24'h0};
			cnt_q    <= 4'd2;
			sum_en_q <= 1'b0;
		end else if (cmd.step_hex) begin
			val_q <= {val_q[27:0], 4'h0};
			cnt_q <= cnt_q - 4'd1;
		end

		if (emit) begin
			unique case (1'b1)
				cmd.step_hex: out_q <= '{out_byte: hex_byte, last_of_item: cmd.hex_last,
				                         frame_end: 1'b0};
				cmd.emit_raw: out_q <= '{out_byte: val_q[7:0], last_of_item: 1'b1,
				                         frame_end: 1'b0};
				cmd.emit_cr:  out_q <= '{out_byte: CHAR_CR, last_of_item: 1'b0,
				                         frame_end: 1'b0};
				default:      out_q <= '{out_byte: CHAR_LF, last_of_item: 1'b1,
				                         frame_end: 1'b1};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step_hex && sum_en_q) begin
				sum_q <= sum_q + hex_byte;
			end else if (cmd.emit_raw) begin
				sum_q <= sum_q + val_q[7:0];
			end else if (cmd.emit_lf) begin
				sum_q <= 8'h00;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/ascii_hex_frame_builder.sv
// Top level of the ASCII hex frame builder.
// Each accepted input beat produces 0 to 8 output beats, one byte each, at up to one
// byte per clock while out_ready allows: a hex item of n digits gives n bytes, a raw
// character 1, a close 2 (no checksum) or 4 (with checksum); the item is taken in the
// idle state first. The controller works on one item at a time and accepts the next
// once its last byte has gone into the output register, even while that byte still
// waits for out_ready. The rate is set by the single output register: one byte leaves
// the digit shifter per cycle while that register is free. Digit counts of 0 are
// treated as 1 and above 8 as 8; action codes 5 to 7 are taken and dropped. The
// 8-bit running sum wraps, skips the checksum digits and clears on every close.
module ascii_hex_frame_builder import ahfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	cmd_t    cmd;
	status_t status;

	// sequencer: decodes the action and steps through the bytes of the item
	ahfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (in_data.action),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: nibble shifter, running checksum, output beat register
	ahfb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
